/* rtl/csd_pkg.sv */
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types and constants of the capsule signed distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package csd_pkg;

  localparam int COORD_W = 32;
  localparam int AXIS_W  = 16;
  localparam int LEN_W   = 31;
  localparam int DIFF_W  = COORD_W + 1;

  // Restoring divider: 32 quotient bits, four per stage.
  localparam int DIV_STAGES = 8;
  localparam int DIV_BPS    = 4;

  // Square root: 32 result bits, four per stage.
  localparam int SQ_STAGES = 8;
  localparam int SQ_BPS    = 4;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd7;

  typedef logic signed [DIFF_W-1:0] diff_t;

  // Values that ride alongside the divider.
  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
    logic  neg;
    logic  uzero;
  } div_side_t;

endpackage

`default_nettype wire

/* rtl/csd_div.sv */
// ----------------------------------------------------------------------------
// csd_div
// Pipelined restoring divider, 64 by 32 bits, 32-bit quotient plus overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_div
  import csd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [63:0] num,
  input  wire logic [31:0] den,
  input  wire div_side_t   in_side,
  output logic             out_valid,
  output logic [31:0]      quo,
  output logic             ovf,
  output div_side_t        out_side
);

  logic [31:0] rem_q  [DIV_STAGES+1];
  logic [31:0] low_q  [DIV_STAGES+1];
  logic        ovf_q  [DIV_STAGES+1];
  logic        vld_q  [DIV_STAGES+1];
  div_side_t   side_q [DIV_STAGES+1];

  // A quotient of 2^32 or more shows up as a high half not below the divisor.
  assign ovf_q[0]  = (num[63:32] >= den);
  assign rem_q[0]  = ovf_q[0] ? 32'd0 : num[63:32];
  assign low_q[0]  = num[31:0];
  assign vld_q[0]  = in_valid;
  assign side_q[0] = in_side;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [31:0] rem_n;
    logic [31:0] low_n;

    always_comb begin : p_steps
      logic [32:0] t;
      rem_n = rem_q[g];
      low_n = low_q[g];
      for (int k = 0; k < DIV_BPS; k++) begin
        t = {rem_n, low_n[31]};
        if (t >= {1'b0, den}) begin
          rem_n = 32'(t - {1'b0, den});
          low_n = {low_n[30:0], 1'b1};
        end else begin
          rem_n = t[31:0];
          low_n = {low_n[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g+1] <= 1'b0;
      end else if (en) begin
        vld_q[g+1] <= vld_q[g];
      end
      if (en) begin
        rem_q[g+1]  <= rem_n;
        low_q[g+1]  <= low_n;
        ovf_q[g+1]  <= ovf_q[g];
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign out_valid = vld_q[DIV_STAGES];
  assign quo       = low_q[DIV_STAGES];
  assign ovf       = ovf_q[DIV_STAGES];
  assign out_side  = side_q[DIV_STAGES];

endmodule

`default_nettype wire

/* rtl/csd_sqrt.sv */
// ----------------------------------------------------------------------------
// csd_sqrt
// Pipelined integer square root, floor of the root of a 64-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_sqrt
  import csd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [63:0] x,
  input  wire logic        in_big,
  output logic             out_valid,
  output logic [31:0]      root,
  output logic             out_big
);

  logic [33:0] rem_q  [SQ_STAGES+1];
  logic [31:0] root_q [SQ_STAGES+1];
  logic [63:0] x_q    [SQ_STAGES+1];
  logic        big_q  [SQ_STAGES+1];
  logic        vld_q  [SQ_STAGES+1];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign x_q[0]    = x;
  assign big_q[0]  = in_big;
  assign vld_q[0]  = in_valid;

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic [33:0] rem_n;
    logic [31:0] root_n;
    logic [63:0] x_n;

    always_comb begin : p_steps
      logic [35:0] t;
      logic [35:0] trial;
      rem_n  = rem_q[g];
      root_n = root_q[g];
      x_n    = x_q[g];
      for (int k = 0; k < SQ_BPS; k++) begin
        t     = {rem_n, x_n[63:62]};
        trial = {2'b00, root_n, 2'b01};
        x_n   = {x_n[61:0], 2'b00};
        if (t >= trial) begin
          rem_n  = 34'(t - trial);
          root_n = {root_n[30:0], 1'b1};
        end else begin
          rem_n  = t[33:0];
          root_n = {root_n[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g+1] <= 1'b0;
      end else if (en) begin
        vld_q[g+1] <= vld_q[g];
      end
      if (en) begin
        rem_q[g+1]  <= rem_n;
        root_q[g+1] <= root_n;
        x_q[g+1]    <= x_n;
        big_q[g+1]  <= big_q[g];
      end
    end
  end

  assign out_valid = vld_q[SQ_STAGES];
  assign root      = root_q[SQ_STAGES];
  assign out_big   = big_q[SQ_STAGES];

endmodule

`default_nettype wire

/* rtl/capsule_signed_distance.sv */
// ----------------------------------------------------------------------------
// capsule_signed_distance
// Signed distance from a streamed 3D point to a configured capsule.
// ----------------------------------------------------------------------------
// Query points enter on the s_ stream (x, y, z in Q16.16) and one distance
// per point leaves on the m_ stream, with a saturation flag in m_tuser.
// The capsule is set through the cfg_ write channel (centre, axis, length,
// radius), which is always ready; write it only while no point is in flight.
// The pipeline is 25 register stages deep. One point is accepted every
// cycle while the output is not stalled. Most of the stages come from the
// 8-stage divider that projects the point onto the axis and the 8-stage
// square root of the squared distance, four bits per stage each.
// The whole pipeline advances together; when m_tready is low with a result
// waiting, every stage holds and s_tready drops, and nothing is lost.
// Bubbles in the pipeline keep it moving while the output register is empty.
// Reset clears all valid bits and loads the default capsule: centre at the
// origin, axis along y, length 1.0 and radius 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module capsule_signed_distance
  import csd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [95:0]          s_tdata,   // point_x, point_y, point_z
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [31:0]               m_tdata,   // distance
  output logic                      m_tuser,   // saturated
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  logic signed [COORD_W-1:0] center_x, center_y, center_z;
  logic signed [AXIS_W-1:0]  axis_x, axis_y, axis_z;
  logic [LEN_W-1:0]          segment_length, radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      center_z       <= '0;
      axis_x         <= '0;
      axis_y         <= 16'sd16384;
      axis_z         <= '0;
      segment_length <= 31'd65536;
      radius         <= 31'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x       <= cfg_data;
        REG_CENTER_Y: center_y       <= cfg_data;
        REG_CENTER_Z: center_z       <= cfg_data;
        REG_AXIS_X:   axis_x         <= cfg_data[15:0];
        REG_AXIS_Y:   axis_y         <= cfg_data[15:0];
        REG_AXIS_Z:   axis_z         <= cfg_data[15:0];
        REG_LENGTH:   segment_length <= cfg_data[30:0];
        REG_RADIUS:   radius         <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: offset from the centre.
  logic  v1;
  diff_t d1x, d1y, d1z;
  // Stage 2: axis products and squared axis norm.
  logic               v2;
  diff_t              d2x, d2y, d2z;
  logic signed [48:0] p2x, p2y, p2z;
  logic [31:0]        uu2;
  // Stage 3: divider operands.
  logic        v3;
  logic [63:0] num3;
  logic [31:0] den3;
  div_side_t   side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1x <= $signed({s_tdata[31], s_tdata[31:0]})  - $signed({center_x[31], center_x});
      d1y <= $signed({s_tdata[63], s_tdata[63:32]}) - $signed({center_y[31], center_y});
      d1z <= $signed({s_tdata[95], s_tdata[95:64]}) - $signed({center_z[31], center_z});
    end
  end

  logic [31:0] sqx, sqy, sqz;
  assign sqx = 32'(axis_x * axis_x);
  assign sqy = 32'(axis_y * axis_y);
  assign sqz = 32'(axis_z * axis_z);

  always_ff @(posedge clk) begin
    if (en) begin
      d2x <= d1x;
      d2y <= d1y;
      d2z <= d1z;
      p2x <= d1x * axis_x;
      p2y <= d1y * axis_y;
      p2z <= d1z * axis_z;
      uu2 <= sqx + sqy + sqz;
    end
  end

  logic signed [50:0] dot2;
  logic [50:0]        mag2;
  assign dot2 = 51'(p2x) + 51'(p2y) + 51'(p2z);
  assign mag2 = dot2[50] ? 51'(-dot2) : dot2;

  // The scaled magnitude wraps at 64 bits, as the arithmetic is defined.
  always_ff @(posedge clk) begin
    if (en) begin
      num3        <= 64'({mag2, 15'd0}) + 64'(uu2 >> 1);
      den3        <= uu2;
      side3.dx    <= d2x;
      side3.dy    <= d2y;
      side3.dz    <= d2z;
      side3.neg   <= dot2[50];
      side3.uzero <= (uu2 == '0);
    end
  end

  logic        vd;
  logic [31:0] qd;
  logic        ovfd;
  div_side_t   sided;

  csd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .num       (num3),
    .den       (den3),
    .in_side   (side3),
    .out_valid (vd),
    .quo       (qd),
    .ovf       (ovfd),
    .out_side  (sided)
  );

  // Stage 4: clamp to the length and restore the sign.
  logic               v4, v5, v6, v7, v8;
  logic signed [31:0] t4;
  diff_t              d4x, d4y, d4z, d5x, d5y, d5z;
  logic signed [47:0] p5x, p5y, p5z;
  logic [31:0]        m6x, m6y, m6z;
  logic               big6, big7, big8;
  logic [63:0]        s7x, s7y, s7z;
  logic [63:0]        sum8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v4 <= vd;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  logic [31:0] q4;
  assign q4 = (ovfd || qd > {1'b0, segment_length}) ? {1'b0, segment_length} : qd;

  always_ff @(posedge clk) begin
    if (en) begin
      t4  <= sided.uzero ? 32'sd0 : (sided.neg ? -$signed(q4) : $signed(q4));
      d4x <= sided.dx;
      d4y <= sided.dy;
      d4z <= sided.dz;
      p5x <= t4 * axis_x;
      p5y <= t4 * axis_y;
      p5z <= t4 * axis_z;
      d5x <= d4x;
      d5y <= d4y;
      d5z <= d4z;
    end
  end

  // Rounds the offset half away from zero and returns |d - offset|.
  function automatic logic [34:0] abs_err(diff_t d, logic signed [47:0] p);
    logic [47:0]        pm;
    logic [33:0]        om;
    logic signed [34:0] off;
    logic signed [34:0] e;
    pm  = p[47] ? 48'(-p) : p;
    om  = 34'((pm + 48'd16384) >> 15);
    off = p[47] ? -$signed({1'b0, om}) : $signed({1'b0, om});
    e   = 35'(d) - off;
    return e[34] ? 35'(-e) : e;
  endfunction

  logic [34:0] ax6, ay6, az6;
  assign ax6 = abs_err(d5x, p5x);
  assign ay6 = abs_err(d5y, p5y);
  assign az6 = abs_err(d5z, p5z);

  logic [65:0] sum7;
  assign sum7 = 66'(s7x) + 66'(s7y) + 66'(s7z);

  always_ff @(posedge clk) begin
    if (en) begin
      m6x  <= ax6[31:0];
      m6y  <= ay6[31:0];
      m6z  <= az6[31:0];
      big6 <= (ax6[34:32] != '0) || (ay6[34:32] != '0) || (az6[34:32] != '0);
      s7x  <= m6x * m6x;
      s7y  <= m6y * m6y;
      s7z  <= m6z * m6z;
      big7 <= big6;
      sum8 <= sum7[63:0];
      big8 <= big7 || (sum7[65:64] != '0);
    end
  end

  logic        vs;
  logic [31:0] root;
  logic        bigs;

  csd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v8),
    .x         (sum8),
    .in_big    (big8),
    .out_valid (vs),
    .root      (root),
    .out_big   (bigs)
  );

  logic signed [32:0] signed_dist;
  assign signed_dist = $signed({1'b0, root}) - $signed({2'b00, radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vs;
    end
    if (en) begin
      if (bigs || signed_dist > 33'sh0_7FFF_FFFF) begin
        m_tdata <= 32'h7FFF_FFFF;
        m_tuser <= 1'b1;
      end else if (signed_dist < -33'sh0_8000_0000) begin
        m_tdata <= 32'h8000_0000;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= signed_dist[31:0];
        m_tuser <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/csd_checker.sv */
// ----------------------------------------------------------------------------
// csd_checker
// Port-level checks of the capsule signed distance block.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_checker
  import csd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [95:0]          s_tdata,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [31:0]          m_tdata,
  input wire logic                 m_tuser,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [31:0]          cfg_data
);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Clipping only ever lands on one of the two range limits.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000)
    else $error("saturated result off the range limits");

  // With the output register empty the pipeline always takes a point.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind capsule_signed_distance csd_checker u_csd_checker (.*);

`default_nettype wire

/* tb/sv/capsule_signed_distance_test.sv */
// ----------------------------------------------------------------------------
// capsule_signed_distance_test
// Self-checking testbench for the capsule signed distance pipeline.
// ----------------------------------------------------------------------------
// Query points stream in through a bursty driver, and the output side stalls
// on its own random pattern. A behavioral model predicts each distance and
// saturation flag from the current capsule setup. The monitor compares every
// result transaction with the oldest prediction. The capsule is rewritten
// between phases, only once the pipeline has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module capsule_signed_distance_test;
  import csd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 25;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } point_t;

  typedef struct {
    logic [31:0] distance;
    logic        saturated;
  } dist_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  capsule_signed_distance dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Capsule setup as the block should hold it.
  longint cap_center [3];
  longint cap_axis [3];
  longint cap_length;
  longint cap_radius;

  point_t pending_points [$];
  dist_t expected_distances [$];
  int mismatches = 0;
  longint cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit stall_mode = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint sqrt_floor(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic dist_t capsule_distance(point_t p);
    dist_t r;
    longint d [3];
    longint dot, uu, tau2, e, offs, signed_dist;
    longint unsigned mag, q, m, sq, sumsq;
    bit big;
    dot = 0; uu = 0; tau2 = 0; sumsq = 0; big = 0;
    d[0] = longint'(p.x) - cap_center[0];
    d[1] = longint'(p.y) - cap_center[1];
    d[2] = longint'(p.z) - cap_center[2];
    for (int i = 0; i < 3; i++) begin
      dot += d[i] * cap_axis[i];
      uu += cap_axis[i] * cap_axis[i];
    end
    if (uu != 0) begin
      mag = dot < 0 ? -dot : dot;
      q = ((mag << 15) + (longint'(uu) >> 1)) / longint'(uu);
      if (q > cap_length) q = cap_length;
      tau2 = dot < 0 ? -longint'(q) : longint'(q);
    end
    for (int i = 0; i < 3; i++) begin
      // Offset along the axis is rounded half away from zero.
      offs = tau2 * cap_axis[i];
      m = offs < 0 ? -offs : offs;
      m = (m + (64'd1 << 14)) >> 15;
      offs = offs < 0 ? -longint'(m) : longint'(m);
      e = d[i] - offs;
      m = e < 0 ? -e : e;
      if (m >= (64'd1 << 32)) begin
        big = 1;
      end else begin
        sq = m * m;
        if (sumsq + sq < sumsq) big = 1;
        sumsq += sq;
      end
    end
    r.saturated = 1'b0;
    if (big) begin
      signed_dist = 64'sd2147483647;
      r.saturated = 1'b1;
    end else begin
      signed_dist = sqrt_floor(sumsq) - cap_radius;
      if (signed_dist > 64'sd2147483647) begin
        signed_dist = 64'sd2147483647;
        r.saturated = 1'b1;
      end else if (signed_dist < -64'sd2147483648) begin
        signed_dist = -64'sd2147483648;
        r.saturated = 1'b1;
      end
    end
    r.distance = signed_dist[31:0];
    return r;
  endfunction

  // Input driver: bursts of transactions separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_distances.push_back(capsule_distance(point_t'(s_tdata)));
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          s_tdata <= pending_points.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with its own stall pattern on the output.
  always @(posedge clk) begin
    dist_t exp_d;
    cycle_count++;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_distances.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: distance %0d", $signed(m_tdata));
        end else begin
          exp_d = expected_distances.pop_front();
          if (m_tdata !== exp_d.distance || m_tuser !== exp_d.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected distance %0d sat %0b, got %0d sat %0b",
                       $signed(exp_d.distance), exp_d.saturated, $signed(m_tdata), m_tuser);
          end
        end
      end
      if ($urandom_range(0, 99) == 0) stall_mode = ~stall_mode;
      m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CENTER_X: cap_center[0] = longint'($signed(value));
      REG_CENTER_Y: cap_center[1] = longint'($signed(value));
      REG_CENTER_Z: cap_center[2] = longint'($signed(value));
      REG_AXIS_X: cap_axis[0] = longint'($signed(value[15:0]));
      REG_AXIS_Y: cap_axis[1] = longint'($signed(value[15:0]));
      REG_AXIS_Z: cap_axis[2] = longint'($signed(value[15:0]));
      REG_LENGTH: cap_length = longint'(value[30:0]);
      REG_RADIUS: cap_radius = longint'(value[30:0]);
      default: ;
    endcase
  endtask

  task automatic setup_capsule(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [30:0] len, logic [30:0] rad);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_AXIS_X, {16'(0), ax});
    write_reg(REG_AXIS_Y, {16'(0), ay});
    write_reg(REG_AXIS_Z, {16'(0), az});
    write_reg(REG_LENGTH, {1'b0, len});
    write_reg(REG_RADIUS, {1'b0, rad});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_pipeline();
    while (pending_points.size() > 0 || s_tvalid || expected_distances.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Coordinates are mostly near the capsule; a share are full-range values.
  function automatic logic [31:0] rand_coord(logic [31:0] base, int spread);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: return base + 32'($signed($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  task automatic random_points(int count, int spread);
    point_t p;
    for (int i = 0; i < count; i++) begin
      p.x = rand_coord(cap_center[0][31:0], spread);
      p.y = rand_coord(cap_center[1][31:0], spread);
      p.z = rand_coord(cap_center[2][31:0], spread);
      pending_points.push_back(p);
    end
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'h8000;
      3: return 16'd0;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  initial begin
    point_t p;
    cap_center[0] = 0; cap_center[1] = 0; cap_center[2] = 0;
    cap_axis[0] = 0; cap_axis[1] = 16384; cap_axis[2] = 0;
    cap_length = 65536;
    cap_radius = 65536;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed points against the reset capsule: ends, middle, extremes.
    p = '{32'sd0, 32'sd0, 32'sd0};              pending_points.push_back(p);
    p = '{32'sd0, 32'sd200000, 32'sd0};         pending_points.push_back(p);
    p = '{32'sd0, -32'sd200000, 32'sd0};        pending_points.push_back(p);
    p = '{32'sd0, 32'sd0, 32'sd65536};          pending_points.push_back(p);
    p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; pending_points.push_back(p);
    p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; pending_points.push_back(p);
    p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0};  pending_points.push_back(p);
    p = '{32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA}; pending_points.push_back(p);
    drain_pipeline();

    // Zero axis, then zero length: both reduce to a sphere.
    setup_capsule(32'd1000, -32'd5000, 32'd70000, 16'd0, 16'd0, 16'd0, 31'd65536, 31'd0);
    random_points(4, 300000);
    drain_pipeline();
    setup_capsule(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 16'h8000, 16'h8000, 16'h8000,
                  31'd0, 31'h7FFF_FFFF);
    random_points(4, 100000);
    drain_pipeline();
    // Largest length, radius of one, and the most negative x axis component.
    setup_capsule(32'd0, 32'd0, 32'd0, 16'h8000, 16'sd16384, -16'sd16384,
                  31'h7FFF_FFFF, 31'd1);
    random_points(5, 1 << 30);
    drain_pipeline();

    for (int phase = 0; phase < 8; phase++) begin
      setup_capsule($urandom(), $urandom(), $urandom(), rand_axis(), rand_axis(),
                    rand_axis(), ($urandom_range(0, 4) == 0) ? 31'h7FFF_FFFF :
                    31'($urandom_range(0, 1 << 22)), ($urandom_range(0, 4) == 0) ?
                    31'($urandom()) : 31'($urandom_range(0, 1 << 20)));
      random_points(100, (phase % 2) ? (1 << 24) : (1 << 18));
      drain_pipeline();
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
